// ===== rtl/core/b64d_pkg.sv =====
// Shared types and constants for the Base64 decoder.
`default_nettype none

package b64d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned GROUP_W = 24;
   localparam int unsigned SEXT_W  = 6;

   localparam logic [BYTE_W-1:0] PAD_CODE = 8'h3D;

   // One unit of work handed from the front to the back: a decoded group of
   // one to three bytes, or a single error result.
   typedef struct packed {
      logic               err;
      logic               last;
      logic [1:0]         count;
      logic [GROUP_W-1:0] bits;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front end: accepts characters, classifies them and assembles 24-bit groups.
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_char_code,
   input  wire logic              req_end_of_stream,
   input  wire logic              q_ready,
   output logic                   q_push,
   output job_type                q_job
);

   logic [GROUP_W-1:0] group_ff, group_in;
   logic [1:0]         pos_ff, pos_in;
   logic [1:0]         pad_ff, pad_in;
   logic               disc_ff, disc_in;

   logic [SEXT_W-1:0]  sextet;
   logic               is_pad;
   logic               is_bad;
   logic               accept;

   assign req_ready = q_ready;
   assign accept    = req_valid & q_ready;

   always_comb begin
      sextet = '0;
      is_pad = 1'b0;
      is_bad = 1'b0;
      if (req_char_code >= 8'h41 && req_char_code <= 8'h5A) begin
         sextet = SEXT_W'(req_char_code - 8'h41);
      end else if (req_char_code >= 8'h61 && req_char_code <= 8'h7A) begin
         sextet = SEXT_W'(req_char_code - 8'h61 + 8'd26);
      end else if (req_char_code >= 8'h30 && req_char_code <= 8'h39) begin
         sextet = SEXT_W'(req_char_code - 8'h30 + 8'd52);
      end else if (req_char_code == 8'h2B) begin
         sextet = 6'd62;
      end else if (req_char_code == 8'h2F) begin
         sextet = 6'd63;
      end else if (req_char_code == PAD_CODE) begin
         is_pad = 1'b1;
      end else begin
         is_bad = 1'b1;
      end
   end

   always_comb begin
      logic               fail;
      logic [GROUP_W-1:0] shifted;
      logic [1:0]         pad_next;

      group_in = group_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      disc_in  = disc_ff;
      q_push   = 1'b0;
      q_job    = '0;
      fail     = 1'b0;
      shifted  = {group_ff[GROUP_W-SEXT_W-1:0], (is_pad ? {SEXT_W{1'b0}} : sextet)};
      pad_next = is_pad ? pad_ff + 2'd1 : pad_ff;

      if (accept) begin
         if (disc_ff) begin
            if (req_end_of_stream) begin
               group_in = '0;
               pos_in   = '0;
               pad_in   = '0;
               disc_in  = 1'b0;
            end
         end else begin
            // A finished padded group ends the data, a pad may not sit in the
            // first two places, and nothing but pads may follow a pad.
            fail = is_bad
                 || (pos_ff == 2'd0 && pad_ff != 2'd0)
                 || (is_pad && pos_ff < 2'd2)
                 || (!is_pad && pad_ff != 2'd0)
                 || (pos_ff != 2'd3 && req_end_of_stream);
            if (fail) begin
               group_in    = '0;
               pos_in      = '0;
               pad_in      = '0;
               disc_in     = !req_end_of_stream;
               q_push      = 1'b1;
               q_job.err   = 1'b1;
               q_job.last  = 1'b1;
               q_job.count = 2'd1;
            end else if (pos_ff != 2'd3) begin
               group_in = shifted;
               pos_in   = pos_ff + 2'd1;
               pad_in   = pad_next;
            end else begin
               q_push      = 1'b1;
               q_job.bits  = shifted;
               q_job.count = 2'd3 - pad_next;
               q_job.last  = req_end_of_stream;
               group_in    = '0;
               pos_in      = '0;
               pad_in      = req_end_of_stream ? 2'd0 : pad_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         pos_ff   <= '0;
         pad_ff   <= '0;
         disc_ff  <= 1'b0;
      end else begin
         group_ff <= group_in;
         pos_ff   <= pos_in;
         pad_ff   <= pad_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// Short job queue between the decoder front end and the byte sequencer.
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   output logic         ready,
   input  wire logic    pop,
   output logic         valid,
   output job_type      head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign ready    = (count_ff != FULL_CNT);
   assign valid    = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push & ready;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back end: splits each job into result items and drives the output register.
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  job_type                 q_job,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [BYTE_W-1:0]       rsp_data_byte,
   output logic                    rsp_last_of_stream,
   output logic                    rsp_decode_error
);

   job_type           cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [1:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;

   logic              out_free;
   logic              final_byte;
   logic [BYTE_W-1:0] sel_byte;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign final_byte = (idx_ff == cur_ff.count - 2'd1);

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = cur_ff.bits[23:16];
         2'd1:    sel_byte = cur_ff.bits[15:8];
         default: sel_byte = cur_ff.bits[7:0];
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      q_pop        = 1'b0;

      if (out_free) begin
         out_valid_in = 1'b0;
      end

      if (out_free && cur_valid_ff) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_ff.err ? '0 : sel_byte;
         out_last_in  = cur_ff.last && final_byte;
         out_err_in   = cur_ff.err;
         if (final_byte) begin
            // Pull the next job in the same cycle so bytes keep streaming.
            cur_valid_in = q_valid;
            cur_in       = q_job;
            q_pop        = q_valid;
            idx_in       = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (!cur_valid_ff && q_valid) begin
         cur_valid_in = 1'b1;
         cur_in       = q_job;
         q_pop        = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data_byte      = out_byte_ff;
   assign rsp_last_of_stream = out_last_ff;
   assign rsp_decode_error   = out_err_ff;

endmodule

`default_nettype wire

// ===== rtl/core/base64_decoder_top.sv =====
// Streaming Base64 decoder, top level.
//
// Input channel (req_*): one ASCII character per item, with req_end_of_stream
// set on the final character of a stream. Output channel (rsp_*): one decoded
// byte per item, with rsp_last_of_stream on the final result of the stream and
// rsp_decode_error on the single error result that a malformed stream gives.
// Both channels use a valid/ready handshake.
//
// The front end takes one character per cycle while the queue has room and
// hands whole groups or errors to a job queue of QUEUE_DEPTH entries. The back
// end moves one byte per cycle, while the output is free, from the queue head
// into the output register. A finished group passes the queue and the
// current-job register on its way out. Four characters give at most three
// bytes, so one character per cycle is sustained; a run of errors is limited
// to one result per cycle by the output register.
//
// Reset clears the group state, the queue and the output register. When the
// receiver stalls, the output register holds, the queue fills, and req_ready
// falls only once the queue is full.
`default_nettype none

module base64_decoder_top
   import b64d_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_char_code,
   input  wire logic              req_end_of_stream,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic                   rsp_last_of_stream,
   output logic                   rsp_decode_error
);

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    q_ready;
   logic    q_valid;
   logic    pop;

   b64d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_stream (req_end_of_stream),
      .q_ready           (q_ready),
      .q_push            (push),
      .q_job             (push_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .ready    (q_ready),
      .pop      (pop),
      .valid    (q_valid),
      .head_job (head_job)
   );

   b64d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_job              (head_job),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_of_stream (rsp_last_of_stream),
      .rsp_decode_error   (rsp_decode_error)
   );

endmodule

`default_nettype wire
